// ----- hdl/tal_pkg.sv -----
// shared types, constants and helpers for the tree ancestor lifting table
// no dependencies
package tal_pkg;

    localparam int MAX_NODES = 4096;
    localparam int LEVELS    = 12;
    localparam int NODE_W    = 12;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int LVL_CNT_W = $clog2(LEVELS + 1);
    localparam int TBL_AW    = NODE_W + LVL_W;
    localparam int DEPTH_W   = 12;

    localparam int DEPTH_CAP_I = ((1 << LEVELS) - 1 < 4095) ? ((1 << LEVELS) - 1) : 4095;
    localparam logic [DEPTH_W:0] DEPTH_CAP = (DEPTH_W + 1)'(DEPTH_CAP_I);

    localparam logic [NODE_W-1:0]  ROOT_NODE = NODE_W'(1);
    localparam logic [NODE_W-1:0]  LAST_NODE = NODE_W'(MAX_NODES - 1);
    localparam logic [LVL_CNT_W-1:0] LVL_TOP = LVL_CNT_W'(LEVELS - 1);
    localparam logic [LVL_CNT_W-1:0] LVL_END = LVL_CNT_W'(LEVELS);

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_ANC  = 2'd1;
    localparam logic [1:0] CMD_LCA  = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] value;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] answer;
        logic              found;
    } out_item_t;

    // ancestor table address: node row, level slot
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [NODE_W-1:0] nd,
                                                   input logic [LVL_CNT_W-1:0] lvl);
        tbl_addr = {nd, lvl[LVL_W-1:0]};
    endfunction

endpackage

// ----- hdl/tree_ancestor_lifting_table.sv -----
// tree ancestor engine: binary lifting table, node depths, k-th ancestor and lca
// depends on tal_pkg
// load writes level 0 at once; load with last then builds: parent fix-up, doubling levels,
//   depth pass; ancestor query reads the depth then lifts one table read per set bit of k;
//   lca query lifts to equal depth then climbs both nodes, all through the one table read port
// throughput: one transaction in flight; the next is taken once the result is in the output register
// reset: control clears at once, then a pass over every node row zeroes level 0 of the table with in_ready low
module tree_ancestor_lifting_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tal_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tal_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic [tal_pkg::NODE_W-1:0] cfg_wdata
);

    typedef enum logic [21:0] {
        S_CLR    = 22'h000001,
        S_IDLE   = 22'h000002,
        S_B1_RD  = 22'h000004,
        S_B1_WR  = 22'h000008,
        S_B2_RA  = 22'h000010,
        S_B2_RB  = 22'h000020,
        S_B2_WR  = 22'h000040,
        S_D_ST   = 22'h000080,
        S_D_RD   = 22'h000100,
        S_D_CHK  = 22'h000200,
        S_D_RD0  = 22'h000400,
        S_D_WR   = 22'h000800,
        S_Q_DA   = 22'h001000,
        S_Q_DB   = 22'h002000,
        S_L_STEP = 22'h004000,
        S_L_WAIT = 22'h008000,
        S_C_RA   = 22'h010000,
        S_C_RB   = 22'h020000,
        S_C_CMP  = 22'h040000,
        S_F_RD   = 22'h080000,
        S_F_WR   = 22'h100000,
        S_DONE   = 22'h200000
    } state_t;

    localparam int NW = tal_pkg::NODE_W;
    localparam int CW = tal_pkg::LVL_CNT_W;
    localparam int AW = tal_pkg::TBL_AW;
    localparam int DW = tal_pkg::DEPTH_W;

    // table memory: one row of lifting slots per node
    logic [NW-1:0] tbl_mem [0:(1 << AW)-1];
    logic [NW-1:0] tr_data_reg;
    logic          tr_en;
    logic [AW-1:0] tr_addr;
    logic          tw_en;
    logic [AW-1:0] tw_addr;
    logic [NW-1:0] tw_data;

    // depth memory, one entry per node
    logic [DW-1:0] dep_mem [0:tal_pkg::MAX_NODES-1];
    logic [DW-1:0] dr_data_reg;
    logic          dr_en;
    logic [NW-1:0] dr_addr;
    logic          dw_en;
    logic [NW-1:0] dw_addr;
    logic [DW-1:0] dw_data;

    state_t        state_reg, state_next;
    logic          ready_reg, ready_next;      // table built and current
    logic [NW-1:0] count_reg, count_next;      // node_count
    logic          ov_reg, ov_next;
    tal_pkg::out_item_t res_reg, res_next;     // output register
    tal_pkg::out_item_t ans_reg, ans_next;     // finished result waiting for the output register
    logic [NW-1:0] v_reg, v_next;              // node sweep counter
    logic [CW-1:0] j_reg, j_next;              // level counter
    logic [NW-1:0] x_reg, x_next;              // walking node a
    logic [NW-1:0] b_reg, b_next;              // walking node b
    logic [NW-1:0] k_reg, k_next;              // lift distance
    logic [DW:0]   d_reg, d_next;              // depth accumulator
    logic [NW-1:0] ta_reg, ta_next;            // ancestor of a at level j
    logic [DW-1:0] da_reg, da_next;
    logic [1:0]    cmd_reg, cmd_next;

    logic q_ok;
    logic [DW:0] d_inc;

    always_ff @(posedge clk)
    begin
        if (tw_en)
        begin
            tbl_mem[tw_addr] <= tw_data;
        end
        if (tr_en)
        begin
            tr_data_reg <= tbl_mem[tr_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dw_en)
        begin
            dep_mem[dw_addr] <= dw_data;
        end
        if (dr_en)
        begin
            dr_data_reg <= dep_mem[dr_addr];
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = res_reg;

    // query node in range and table current
    assign q_ok  = ready_reg && (in_data.node != '0) && (in_data.node <= count_reg);
    assign d_inc = d_reg + (DW + 1)'(1);

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        count_next = count_reg;
        ov_next    = ov_reg && !out_ready;
        res_next   = res_reg;
        ans_next   = ans_reg;
        v_next     = v_reg;
        j_next     = j_reg;
        x_next     = x_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        d_next     = d_reg;
        ta_next    = ta_reg;
        da_next    = da_reg;
        cmd_next   = cmd_reg;
        tr_en      = 1'b0;
        tr_addr    = tal_pkg::tbl_addr(x_reg, j_reg);
        tw_en      = 1'b0;
        tw_addr    = tal_pkg::tbl_addr(v_reg, j_reg);
        tw_data    = tr_data_reg;
        dr_en      = 1'b0;
        dr_addr    = x_reg;
        dw_en      = 1'b0;
        dw_addr    = v_reg;
        dw_data    = '0;

        if (cfg_we)
        begin
            count_next = cfg_wdata;
            ready_next = 1'b0;
        end

        unique case (state_reg)
            // zero every parent slot so an unloaded node hangs off the root
            S_CLR:
            begin
                tw_en   = 1'b1;
                tw_addr = tal_pkg::tbl_addr(v_reg, '0);
                tw_data = '0;
                v_next  = v_reg + NW'(1);
                if (v_reg == tal_pkg::LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = in_data.cmd;
                    x_next   = in_data.node;
                    b_next   = in_data.value;
                    k_next   = in_data.value;
                    if (in_data.cmd == tal_pkg::CMD_LOAD)
                    begin
                        if (in_data.node >= NW'(2) && in_data.node <= count_reg)
                        begin
                            tw_en   = 1'b1;
                            tw_addr = tal_pkg::tbl_addr(in_data.node, '0);
                            tw_data = in_data.value;
                        end
                        ready_next = 1'b0;
                        if (in_data.last)
                        begin
                            if (count_reg == '0)
                            begin
                                // no nodes in use: the build is empty
                                ready_next = 1'b1;
                            end
                            else
                            begin
                                v_next     = tal_pkg::ROOT_NODE;
                                state_next = S_B1_RD;
                            end
                        end
                    end
                    else if (q_ok && (in_data.cmd == tal_pkg::CMD_ANC ||
                             (in_data.cmd == tal_pkg::CMD_LCA && in_data.value != '0 &&
                              in_data.value <= count_reg)))
                    begin
                        dr_en      = 1'b1;
                        dr_addr    = in_data.node;
                        state_next = S_Q_DA;
                    end
                    else
                    begin
                        ans_next   = '{answer: '0, found: 1'b0};
                        state_next = S_DONE;
                    end
                end
            end
            // build, first pass: fix up bad or missing parents
            S_B1_RD:
            begin
                tr_en      = 1'b1;
                tr_addr    = tal_pkg::tbl_addr(v_reg, '0);
                state_next = S_B1_WR;
            end
            S_B1_WR:
            begin
                tw_addr = tal_pkg::tbl_addr(v_reg, '0);
                tw_data = tal_pkg::ROOT_NODE;
                if (v_reg == tal_pkg::ROOT_NODE || tr_data_reg == '0 ||
                    tr_data_reg > count_reg)
                begin
                    tw_en = 1'b1;
                end
                if (v_reg == count_reg)
                begin
                    v_next     = tal_pkg::ROOT_NODE;
                    j_next     = CW'(1);
                    state_next = (CW'(1) == tal_pkg::LVL_END) ? S_D_ST : S_B2_RA;
                end
                else
                begin
                    v_next     = v_reg + NW'(1);
                    state_next = S_B1_RD;
                end
            end
            // build, doubling levels: T[v][j] = T[T[v][j-1]][j-1]
            S_B2_RA:
            begin
                tr_en      = 1'b1;
                tr_addr    = tal_pkg::tbl_addr(v_reg, j_reg - CW'(1));
                state_next = S_B2_RB;
            end
            S_B2_RB:
            begin
                tr_en      = 1'b1;
                tr_addr    = tal_pkg::tbl_addr(tr_data_reg, j_reg - CW'(1));
                state_next = S_B2_WR;
            end
            S_B2_WR:
            begin
                tw_en = 1'b1;
                if (v_reg == count_reg)
                begin
                    v_next = tal_pkg::ROOT_NODE;
                    if (j_reg == tal_pkg::LVL_TOP)
                    begin
                        state_next = S_D_ST;
                    end
                    else
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = S_B2_RA;
                    end
                end
                else
                begin
                    v_next     = v_reg + NW'(1);
                    state_next = S_B2_RA;
                end
            end
            // depth pass: lift toward the root, largest jumps first
            S_D_ST:
            begin
                x_next = v_reg;
                d_next = '0;
                j_next = tal_pkg::LVL_TOP;
                if (v_reg == tal_pkg::ROOT_NODE)
                begin
                    dw_en = 1'b1;
                    if (v_reg == count_reg)
                    begin
                        ready_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        v_next = v_reg + NW'(1);
                    end
                end
                else
                begin
                    state_next = S_D_RD;
                end
            end
            S_D_RD:
            begin
                tr_en      = 1'b1;
                state_next = S_D_CHK;
            end
            S_D_CHK:
            begin
                if (tr_data_reg != tal_pkg::ROOT_NODE)
                begin
                    x_next = tr_data_reg;
                    d_next = d_reg + ((DW + 1)'(1) << j_reg);
                end
                if (j_reg == '0)
                begin
                    state_next = S_D_RD0;
                end
                else
                begin
                    j_next     = j_reg - CW'(1);
                    state_next = S_D_RD;
                end
            end
            S_D_RD0:
            begin
                tr_en      = 1'b1;
                tr_addr    = tal_pkg::tbl_addr(x_reg, '0);
                state_next = S_D_WR;
            end
            S_D_WR:
            begin
                dw_en = 1'b1;
                // off-root chains and deep trees saturate
                if (tr_data_reg == tal_pkg::ROOT_NODE && d_inc <= tal_pkg::DEPTH_CAP)
                begin
                    dw_data = d_inc[DW-1:0];
                end
                else
                begin
                    dw_data = tal_pkg::DEPTH_CAP[DW-1:0];
                end
                if (v_reg == count_reg)
                begin
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    v_next     = v_reg + NW'(1);
                    state_next = S_D_ST;
                end
            end
            // query: fetch depths
            S_Q_DA:
            begin
                da_next = dr_data_reg;
                j_next  = '0;
                if (cmd_reg == tal_pkg::CMD_ANC)
                begin
                    if (k_reg <= dr_data_reg)
                    begin
                        state_next = S_L_STEP;
                    end
                    else
                    begin
                        ans_next   = '{answer: '0, found: 1'b0};
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    dr_en      = 1'b1;
                    dr_addr    = b_reg;
                    state_next = S_Q_DB;
                end
            end
            S_Q_DB:
            begin
                // deeper node walks up by the depth difference
                if (da_reg < dr_data_reg)
                begin
                    x_next = b_reg;
                    b_next = x_reg;
                    k_next = dr_data_reg - da_reg;
                end
                else
                begin
                    k_next = da_reg - dr_data_reg;
                end
                state_next = S_L_STEP;
            end
            S_L_STEP:
            begin
                if (j_reg == tal_pkg::LVL_END)
                begin
                    if (cmd_reg == tal_pkg::CMD_ANC || x_reg == b_reg)
                    begin
                        ans_next   = '{answer: x_reg, found: 1'b1};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        j_next     = tal_pkg::LVL_TOP;
                        state_next = S_C_RA;
                    end
                end
                else if (k_reg[j_reg[tal_pkg::LVL_W-1:0]])
                begin
                    tr_en      = 1'b1;
                    state_next = S_L_WAIT;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            S_L_WAIT:
            begin
                x_next     = tr_data_reg;
                j_next     = j_reg + CW'(1);
                state_next = S_L_STEP;
            end
            // lca: climb both while their ancestors differ
            S_C_RA:
            begin
                tr_en      = 1'b1;
                state_next = S_C_RB;
            end
            S_C_RB:
            begin
                ta_next    = tr_data_reg;
                tr_en      = 1'b1;
                tr_addr    = tal_pkg::tbl_addr(b_reg, j_reg);
                state_next = S_C_CMP;
            end
            S_C_CMP:
            begin
                if (ta_reg != tr_data_reg)
                begin
                    x_next = ta_reg;
                    b_next = tr_data_reg;
                end
                if (j_reg == '0)
                begin
                    state_next = S_F_RD;
                end
                else
                begin
                    j_next     = j_reg - CW'(1);
                    state_next = S_C_RA;
                end
            end
            S_F_RD:
            begin
                tr_en      = 1'b1;
                tr_addr    = tal_pkg::tbl_addr(x_reg, '0);
                state_next = S_F_WR;
            end
            S_F_WR:
            begin
                ans_next   = '{answer: tr_data_reg, found: 1'b1};
                state_next = S_DONE;
            end
            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    res_next   = ans_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ready_reg <= 1'b0;
            count_reg <= tal_pkg::ROOT_NODE;
            ov_reg    <= 1'b0;
            v_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            v_reg     <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        ans_reg <= ans_next;
        j_reg   <= j_next;
        x_reg   <= x_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        d_reg   <= d_next;
        ta_reg  <= ta_next;
        da_reg  <= da_next;
        cmd_reg <= cmd_next;
    end

endmodule

// ----- tb/tb_tree_ancestor_lifting_table.sv -----
// testbench for tree_ancestor_lifting_table: directed table then random tree builds and queries
// depends on tal_pkg and the tree_ancestor_lifting_table rtl
module tb_tree_ancestor_lifting_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int NW = tal_pkg::NODE_W;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    tal_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    tal_pkg::out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [NW-1:0] cfg_wdata = '0;

    always #5 clk = ~clk;

    tree_ancestor_lifting_table uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // predictor state: level-0 parents as loaded, built lifting table, depths
    logic [NW-1:0] parent_mem [tal_pkg::MAX_NODES];
    logic [NW-1:0] lift_tbl [tal_pkg::MAX_NODES][tal_pkg::LEVELS];
    logic [NW-1:0] depth_mem [tal_pkg::MAX_NODES];
    logic tree_built;
    logic [NW-1:0] nodes_in_use;
    tal_pkg::out_item_t answer_q[$];
    int errors = 0;
    int hold_off = 0;
    int out_wait = 0;
    int quiet_cycles = 0;

    function automatic logic [NW-1:0] capped_count();
        return (nodes_in_use > tal_pkg::LAST_NODE) ? tal_pkg::LAST_NODE : nodes_in_use;
    endfunction

    // mirror of the rtl build: missing or bad parents hang off the root, fixed in place
    task automatic rebuild_tree();
        int cnt;
        int x;
        int d;
        cnt = capped_count();
        for (int v = 1; v <= cnt; v++)
        begin
            if (v == 1 || parent_mem[v] == 0 || parent_mem[v] > cnt)
                parent_mem[v] = tal_pkg::ROOT_NODE;
            lift_tbl[v][0] = parent_mem[v];
        end
        for (int j = 1; j < tal_pkg::LEVELS; j++)
            for (int v = 1; v <= cnt; v++)
                lift_tbl[v][j] = lift_tbl[lift_tbl[v][j-1]][j-1];
        for (int v = 1; v <= cnt; v++)
        begin
            x = v;
            d = 0;
            if (v == 1)
            begin
                depth_mem[v] = '0;
                continue;
            end
            for (int j = tal_pkg::LEVELS - 1; j >= 0; j--)
                if (lift_tbl[x][j] != tal_pkg::ROOT_NODE)
                begin
                    x = lift_tbl[x][j];
                    d += 1 << j;
                end
            // a chain that never meets the root saturates
            if (lift_tbl[x][0] == tal_pkg::ROOT_NODE)
                d = (d + 1 > tal_pkg::DEPTH_CAP_I) ? tal_pkg::DEPTH_CAP_I : d + 1;
            else
                d = tal_pkg::DEPTH_CAP_I;
            depth_mem[v] = NW'(d);
        end
        tree_built = 1'b1;
    endtask

    function automatic logic [NW-1:0] climb(logic [NW-1:0] x, logic [NW-1:0] k);
        for (int j = 0; j < tal_pkg::LEVELS; j++)
            if (k[j])
                x = lift_tbl[x][j];
        return x;
    endfunction

    // predicts one transaction; loads give no answer
    task automatic predict_answer(tal_pkg::in_item_t it);
        tal_pkg::out_item_t r;
        logic [NW-1:0] a;
        logic [NW-1:0] b;
        logic [NW-1:0] t;
        int cnt;
        cnt = capped_count();
        r = '0;
        if (it.cmd == tal_pkg::CMD_LOAD)
        begin
            if (it.node >= 2 && it.node <= cnt)
                parent_mem[it.node] = it.value;
            tree_built = 1'b0;
            if (it.last)
                rebuild_tree();
            return;
        end
        if (tree_built && it.node >= 1 && it.node <= cnt)
        begin
            if (it.cmd == tal_pkg::CMD_ANC)
            begin
                if (it.value <= depth_mem[it.node])
                begin
                    r.answer = climb(it.node, it.value);
                    r.found = 1'b1;
                end
            end
            else if (it.cmd == tal_pkg::CMD_LCA && it.value >= 1 && it.value <= cnt)
            begin
                a = it.node;
                b = it.value;
                if (depth_mem[a] < depth_mem[b])
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                a = climb(a, depth_mem[a] - depth_mem[b]);
                if (a != b)
                begin
                    for (int j = tal_pkg::LEVELS - 1; j >= 0; j--)
                        if (lift_tbl[a][j] != lift_tbl[b][j])
                        begin
                            a = lift_tbl[a][j];
                            b = lift_tbl[b][j];
                        end
                    a = lift_tbl[a][0];
                end
                r.answer = a;
                r.found = 1'b1;
            end
        end
        answer_q = {answer_q, r};
    endtask

    // one transaction on the input side, with a random gap first;
    // with no gap valid stays high and the next transaction follows at once
    task automatic send_item(tal_pkg::in_item_t it);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_answer(it);
    endtask

    // stop offering, wait until every answer is back and any build has finished
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_count(logic [NW-1:0] n);
        cfg_we <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we <= 1'b0;
        nodes_in_use = n;
        tree_built = 1'b0;
        @(posedge clk);
    endtask

    function automatic tal_pkg::in_item_t mk(logic [1:0] c, int n, int v, bit l);
        tal_pkg::in_item_t it;
        it.cmd = c;
        it.node = NW'(n);
        it.value = NW'(v);
        it.last = l;
        return it;
    endfunction

    // loads a random tree of n nodes; parents mostly below the child
    task automatic load_tree(int n, bit noisy);
        int p;
        for (int v = 2; v <= n; v++)
        begin
            p = $urandom_range(1, v - 1);
            if (noisy && $urandom_range(0, 9) == 0)
                p = $urandom_range(0, 4095);
            send_item(mk(tal_pkg::CMD_LOAD, v, p, v == n));
        end
        if (n < 2)
            send_item(mk(tal_pkg::CMD_LOAD, 1, $urandom_range(0, 4095), 1'b1));
    endtask

    function automatic tal_pkg::in_item_t rand_query(int n);
        tal_pkg::in_item_t it;
        it = mk(($urandom_range(0, 1) == 0) ? tal_pkg::CMD_ANC : tal_pkg::CMD_LCA,
                $urandom_range(1, n), 0, $urandom_range(0, 1));
        if (it.cmd == tal_pkg::CMD_ANC)
            it.value = NW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, n));
        else
            it.value = NW'($urandom_range(1, n));
        // a slice of noise: bad nodes, bad values and the unused command
        case ($urandom_range(0, 19))
            0: it.node = NW'($urandom_range(0, 4095));
            1: it.cmd = CMD_UNUSED;
            2: it.value = NW'($urandom_range(0, 4095));
            default: ;
        endcase
        return it;
    endfunction

    // directed rows: command, node, value, last, whether the answer is fixed, and the answer wanted
    typedef struct {
        tal_pkg::in_item_t  stim;
        bit                 fixed;
        tal_pkg::out_item_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    task automatic add_row(tal_pkg::in_item_t it, bit fixed, logic [NW-1:0] ans, bit fnd);
        dir_row_t r;
        r.stim = it;
        r.fixed = fixed;
        r.want.answer = ans;
        r.want.found = fnd;
        dir_rows = {dir_rows, r};
    endtask

    // output side: random wait per transaction, one long hold-off
    always @(posedge clk)
    begin
        int g;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_wait <= 0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            g = $urandom_range(0, 5);
            out_wait <= g;
            out_ready <= (g == 0);
        end
        else if (out_wait > 0)
        begin
            out_wait <= out_wait - 1;
            out_ready <= (out_wait == 1);
        end
        else
            out_ready <= 1'b1;
    end

    // checker: each answer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected answer, expected none, actual %h found %b", $time,
                         out_data.answer, out_data.found);
                errors++;
            end
            else
            begin
                if (out_data.answer !== answer_q[0].answer ||
                    out_data.found !== answer_q[0].found)
                begin
                    $display("%0t: mismatch expected answer %h found %b, actual %h found %b",
                             $time, answer_q[0].answer, answer_q[0].found,
                             out_data.answer, out_data.found);
                    errors++;
                end
                void'(answer_q.pop_front());
            end
        end
    end

    // watchdog on cycles without a transaction; the full-count build is the longest quiet stretch
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        tal_pkg::in_item_t it;
        int n;
        int sizes[4] = '{1, 2, 9, 31};
        for (int i = 0; i < tal_pkg::MAX_NODES; i++)
            parent_mem[i] = '0;
        tree_built = 1'b0;
        nodes_in_use = tal_pkg::ROOT_NODE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // query before any build: nothing found
        add_row(mk(tal_pkg::CMD_ANC, 1, 0, 0), 1, '0, 0);
        add_row(mk(tal_pkg::CMD_LCA, 1, 1, 1), 1, '0, 0);
        // lone root: load of root is ignored but still builds
        add_row(mk(tal_pkg::CMD_LOAD, 1, 4095, 1), 0, '0, 0);
        add_row(mk(tal_pkg::CMD_ANC, 1, 0, 0), 1, 12'd1, 1);
        add_row(mk(tal_pkg::CMD_ANC, 1, 1, 0), 1, '0, 0);
        add_row(mk(tal_pkg::CMD_LCA, 1, 1, 0), 1, 12'd1, 1);
        add_row(mk(tal_pkg::CMD_ANC, 0, 0, 0), 1, '0, 0);
        add_row(mk(CMD_UNUSED, 1, 1, 1), 1, '0, 0);
        add_row(mk(tal_pkg::CMD_ANC, 4095, 4095, 1), 1, '0, 0);
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].stim);
            if (dir_rows[i].fixed && !(answer_q[$].answer === dir_rows[i].want.answer &&
                                       answer_q[$].found === dir_rows[i].want.found))
            begin
                $display("%0t: directed row %0d predictor expected %h/%b got %h/%b", $time,
                         i, dir_rows[i].want.answer, dir_rows[i].want.found,
                         answer_q[$].answer, answer_q[$].found);
                errors++;
            end
        end
        drain_and_settle();

        // small chain with invalid parent, node 0 load, a cycle off the root
        write_count(12'd6);
        send_item(mk(tal_pkg::CMD_LOAD, 2, 1, 0));
        send_item(mk(tal_pkg::CMD_LOAD, 3, 2, 0));
        send_item(mk(tal_pkg::CMD_LOAD, 4, 4095, 0));
        send_item(mk(tal_pkg::CMD_LOAD, 0, 3, 0));
        send_item(mk(tal_pkg::CMD_LOAD, 5, 6, 0));
        send_item(mk(tal_pkg::CMD_LOAD, 6, 5, 1));
        for (int i = 0; i < 12; i++)
            send_item(mk(i % 2 ? tal_pkg::CMD_LCA : tal_pkg::CMD_ANC, 1 + i % 6,
                         (i * 7) % 8, 0));
        send_item(mk(tal_pkg::CMD_ANC, 5, 4095, 0));
        send_item(mk(tal_pkg::CMD_LCA, 3, 7, 0));
        drain_and_settle();

        // random phases on small trees and one full-count chain, with a long output stall in one
        for (int ph = 0; ph < 40; ph++)
        begin
            n = sizes[ph % 4] + $urandom_range(0, 20);
            if (ph == 3)
                n = 4095;
            write_count(NW'(n));
            if (ph == 3)
            begin
                // deep chain across the full count, then a few probes
                for (int v = 2; v <= 40; v++)
                    send_item(mk(tal_pkg::CMD_LOAD, v, v - 1, 0));
                send_item(mk(tal_pkg::CMD_LOAD, 4095, 40, 1));
                send_item(mk(tal_pkg::CMD_ANC, 4095, 41, 0));
                send_item(mk(tal_pkg::CMD_ANC, 4095, 40, 0));
                send_item(mk(tal_pkg::CMD_LCA, 4095, 2, 1));
                send_item(mk(tal_pkg::CMD_LCA, 4000, 4095, 1));
                drain_and_settle();
                continue;
            end
            load_tree(n, ph % 3 == 0);
            if (ph == 5)
                hold_off = 300;
            for (int q = 0; q < 30; q++)
            begin
                it = rand_query(n);
                // reload within a phase: the tree is then rebuilt
                if (q == 20 && ph % 5 == 1)
                    it = mk(tal_pkg::CMD_LOAD, $urandom_range(2, 31),
                            $urandom_range(0, 4095), 1);
                send_item(it);
            end
            drain_and_settle();
        end

        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
